// ----- design/lkv_pkg.sv -----
package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;

  localparam logic [0:0] ACT_GET = 1'b0;
  localparam logic [0:0] ACT_PUT = 1'b1;

  // cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_HIT    = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  localparam logic [2:0] ADDR_CAPACITY = 3'd0;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    logic       keep_ok;  // cell stays within kept range on insert
  } cell_ctrl_t;

endpackage

// ----- design/lkv_cell.sv -----
module lkv_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lkv_pkg::cell_ctrl_t             ctrl,
  input  logic signed [lkv_pkg::KEY_W-1:0] req_key,
  input  lkv_pkg::entry_t                 prev,
  input  logic                            seen_in,
  output lkv_pkg::entry_t                 entry,
  output logic                            match,
  output logic                            seen_out
);

  logic                             valid_r, valid_nxt;
  logic signed [lkv_pkg::KEY_W-1:0] key_r, key_nxt;
  logic signed [lkv_pkg::VAL_W-1:0] value_r, value_nxt;
  logic                             take;

  assign match    = valid_r && (key_r == req_key);
  assign seen_out = seen_in | match;
  assign entry    = '{valid: valid_r, key: key_r, value: value_r};

  always_comb begin
    take      = 1'b0;
    valid_nxt = valid_r;
    unique case (ctrl.op)
      lkv_pkg::OP_HIT: begin
        // cells up to and including the hit slot move up one
        take = !seen_in;
      end
      lkv_pkg::OP_INSERT: begin
        take = ctrl.keep_ok;
        if (!ctrl.keep_ok) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
        take = 1'b0;
      end
    endcase
    if (take) begin
      valid_nxt = prev.valid;
    end
    key_nxt   = take ? prev.key   : key_r;
    value_nxt = take ? prev.value : value_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

// ----- design/lru_key_value_cache.sv -----
// LRU key-value cache.
// in_*  : request stream. in_tuser = action (0 get, 1 put);
//         in_tdata = key [31:0], value [63:32].
// out_* : one result per get, none per put. out_tuser = hit;
//         out_tdata = read_value (stored value on hit, -1 on miss).
// cfg_* : APB-style port; capacity at byte address 0 (5 bits, reset 16).
//         Write it only while no request is outstanding.
// Entries live in a row of cells, cell 0 the most recent. Each request
// broadcasts its key, every cell compares at once, and cells up to and including the hit
// (or all kept cells on insert) take the contents of their lower neighbor.
// Throughput: one transfer per cycle while the receiver keeps up. A get
// result sits in the output register the cycle after its transfer; the
// compare plus the hit chain through the cells sets the cycle time.
// When the receiver stalls, the result holds and a new request is taken
// only in the cycle the result is taken (puts likewise wait for it).
// Reset (synchronous, rst_n low) clears all valid marks, occupancy and the
// output valid flag, and sets capacity to 16; no clearing pass is needed.
module lru_key_value_cache (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key [31:0], value [63:32]
  input  logic        in_tuser,   // action [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_value [31:0]
  output logic        out_tuser,  // hit [0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int N = lkv_pkg::MAX_ENTRIES;

  logic [lkv_pkg::CAP_W-1:0] cap_r;
  logic [lkv_pkg::OCC_W-1:0] occ_r, occ_nxt;
  logic                      out_valid_r, out_hit_r;
  logic signed [lkv_pkg::VAL_W-1:0] out_value_r;

  logic                             in_fire, cfg_wr;
  logic [0:0]                       action;
  logic signed [lkv_pkg::KEY_W-1:0] req_key;
  logic signed [lkv_pkg::VAL_W-1:0] req_value, hit_value;
  logic                             hit;
  logic [lkv_pkg::OCC_W-1:0]        eff_cap, keep;
  logic [1:0]                       op;
  lkv_pkg::entry_t                  front;

  lkv_pkg::entry_t     entries [N];
  lkv_pkg::cell_ctrl_t ctrls   [N];
  logic [N-1:0]        match_vec, valid_vec, therm;
  logic [N:0]          seen;

  // ---------------- config port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == lkv_pkg::ADDR_CAPACITY[2])
                      ? {{(32-lkv_pkg::CAP_W){1'b0}}, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkv_pkg::CAP_RESET;
    end else if (cfg_wr && cfg_paddr[2] == lkv_pkg::ADDR_CAPACITY[2]) begin
      cap_r <= cfg_pwdata[lkv_pkg::CAP_W-1:0];
    end
  end

  // ---------------- request decode ----------------
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign action    = in_tuser;
  assign req_key   = in_tdata[31:0];
  assign req_value = in_tdata[63:32];

  assign hit = seen[N];

  // hit slot is unique, so an OR of gated values selects it
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < N; i++) begin
      if (match_vec[i]) begin
        hit_value = hit_value | entries[i].value;
      end
    end
  end

  // capacity zero acts as one, above the row size as the row size
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = lkv_pkg::OCC_W'(1);
    end else if (int'(cap_r) > N) begin
      eff_cap = lkv_pkg::OCC_W'(N);
    end else begin
      eff_cap = lkv_pkg::OCC_W'(cap_r);
    end
    keep = (occ_r >= eff_cap) ? eff_cap - lkv_pkg::OCC_W'(1) : occ_r;
  end

  always_comb begin
    op      = lkv_pkg::OP_HOLD;
    occ_nxt = occ_r;
    if (in_fire) begin
      priority if (hit) begin
        op = lkv_pkg::OP_HIT;
      end else if (action == lkv_pkg::ACT_PUT) begin
        op      = lkv_pkg::OP_INSERT;
        occ_nxt = keep + lkv_pkg::OCC_W'(1);
      end else begin
        op = lkv_pkg::OP_HOLD;
      end
    end
  end

  // what enters cell 0: the refreshed hit entry or the new pair
  assign front = '{valid: 1'b1, key: req_key,
                   value: (action == lkv_pkg::ACT_PUT) ? req_value : hit_value};

  // ---------------- cell row ----------------
  assign seen[0] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    assign ctrls[g] = '{op: op, keep_ok: (lkv_pkg::OCC_W'(g) <= keep)};
    assign valid_vec[g] = entries[g].valid;
    assign therm[g]     = lkv_pkg::OCC_W'(g) < occ_r;

    lkv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrls[g]),
      .req_key  (req_key),
      .prev     ((g == 0) ? front : entries[(g == 0) ? 0 : g-1]),
      .seen_in  (seen[g]),
      .entry    (entries[g]),
      .match    (match_vec[g]),
      .seen_out (seen[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && action == lkv_pkg::ACT_GET) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && action == lkv_pkg::ACT_GET) begin
      out_hit_r   <= hit;
      out_value_r <= hit ? hit_value : lkv_pkg::MISS_VALUE;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = out_value_r;

  // ---------------- assertions ----------------
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= N)
    else $error("occupancy above row size");

  a_valid_therm: assert property (@(posedge clk) disable iff (!rst_n)
    valid_vec == therm)
    else $error("valid marks disagree with occupancy");

  a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("key held in more than one cell");

  a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && action == lkv_pkg::ACT_GET |=> out_valid_r)
    else $error("get transfer without result");

  a_hit_front: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (hit || action == lkv_pkg::ACT_PUT) |=>
      entries[0].valid && entries[0].key == $past(req_key))
    else $error("accessed key not at front");

endmodule
